FILE: hw/rtl/ltd_pkg.sv
// Shared types and constants for the least-loaded task dispatcher.
// Used by ltd_ctrl, ltd_datapath and least_loaded_task_dispatcher_unit.
// Depends on nothing.
package ltd_pkg;

  // Server pool size and derived widths
  localparam int MAX_SERVERS = 16;
  localparam int SRV_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

  // Fixed field widths
  localparam int LOAD_W      = 32;
  localparam int TIME_W      = 16;
  localparam int CFG_W       = 5;
  localparam int IDX_OUT_W   = 4;

  // Reset value of the server count register
  localparam logic [CFG_W-1:0] NUM_SERVERS_RST = CFG_W'(16);

  // Request operation codes
  typedef enum logic [0:0] {
    OP_ASSIGN = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_CLEAR
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic step;
    logic write;
    logic clear;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

FILE: hw/rtl/least_loaded_task_dispatcher_unit.sv
// Least-loaded task dispatcher, greedy list scheduling over up to 16 servers: assign
// requests go to the server in use with the smallest load (lowest index on a tie) and
// report the chosen server, its saturated new load and the makespan; a clear request
// zeroes all loads. A request is taken when start is high and busy is low. With n the
// number of servers in use (num_servers clamped into 1..16), an assign request keeps busy
// high while it scans the n servers in use one at a time (the load registers have a
// single scan read port) and then writes back; a clear request keeps busy high while it
// zeroes the loads. Each result shows on the result ports for one cycle with done high,
// in the first cycle in which busy is low again, where a new request can already be
// taken; the result cannot be held off, so capture it when done is high. The user must
// write num_servers through cfg_we/cfg_wdata while the block is idle; it is not enforced.
// Depends on ltd_pkg, ltd_ctrl and ltd_datapath.
module least_loaded_task_dispatcher_unit
  import ltd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 operation,
  input  logic [TIME_W-1:0]    task_time,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 done,
  output logic [IDX_OUT_W-1:0] server_index,
  output logic [LOAD_W-1:0]    new_load,
  output logic [LOAD_W-1:0]    makespan
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  ltd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Load storage and arithmetic
  ltd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .task_time    (task_time),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .server_index (server_index),
    .new_load     (new_load),
    .makespan     (makespan)
  );

  // A result never shows while a request is in flight
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // The makespan covers the chosen server's new load
  a_makespan_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (makespan >= new_load))
    else $error("makespan below new load");

  // A clear request returns an all-zero result through the clear state and the done register
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_CLEAR) |=> ##1
      (done && server_index == '0 && new_load == '0 && makespan == '0))
    else $error("clear request result wrong");

endmodule

FILE: hw/rtl/ltd_ctrl.sv
// Sequencer for the dispatcher: accept, scan, write back, clear.
// Drives ltd_datapath through dp_cmd_t; depends on ltd_pkg.
module ltd_ctrl
  import ltd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       operation,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequence and issue datapath commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    busy        = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          if (operation == OP_CLEAR) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ltd_datapath.sv
// Load registers, argmin/max scan unit, saturating adder and result registers.
// Commanded by ltd_ctrl through dp_cmd_t; depends on ltd_pkg.
module ltd_datapath
  import ltd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [TIME_W-1:0]    task_time,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 done,
  output logic [IDX_OUT_W-1:0] server_index,
  output logic [LOAD_W-1:0]    new_load,
  output logic [LOAD_W-1:0]    makespan
);

  logic [CFG_W-1:0]  num_servers;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_reg;
  logic [TIME_W-1:0] task_reg;
  logic [SRV_W-1:0]  idx;
  logic [SRV_W-1:0]  best;
  logic [LOAD_W-1:0] min_val;
  logic [LOAD_W-1:0] max_val;
  logic [LOAD_W-1:0] loads [MAX_SERVERS];
  logic [LOAD_W-1:0] cur;
  logic [LOAD_W:0]   sum_wide;
  logic [LOAD_W-1:0] sum_sat;
  logic [LOAD_W-1:0] top;

  // Hold the server count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= NUM_SERVERS_RST;
    end else if (cfg_we) begin
      num_servers <= cfg_wdata;
    end
  end

  // Clamp the server count into 1..MAX_SERVERS
  always_comb begin
    if (num_servers == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(num_servers) > MAX_SERVERS) begin
      n_eff = CNT_W'(MAX_SERVERS);
    end else begin
      n_eff = CNT_W'(num_servers);
    end
  end

  // Scan read port and end-of-scan flag
  assign cur              = loads[idx];
  assign status.scan_last = (CNT_W'(idx) + CNT_W'(1)) == n_reg;

  // Add the task and saturate; the new top is the scanned max or the new load
  assign sum_wide = {1'b0, min_val} + (LOAD_W + 1)'(task_reg);
  assign sum_sat  = sum_wide[LOAD_W] ? '1 : sum_wide[LOAD_W-1:0];
  assign top      = (sum_sat > max_val) ? sum_sat : max_val;

  // Capture the request and walk the servers one per cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      task_reg <= task_time;
      n_reg    <= n_eff;
      idx      <= '0;
    end else if (cmd.step) begin
      if (idx == '0) begin
        min_val <= cur;
        max_val <= cur;
        best    <= '0;
      end else begin
        if (cur < min_val) begin
          min_val <= cur;
          best    <= idx;
        end
        if (cur > max_val) begin
          max_val <= cur;
        end
      end
      idx <= idx + SRV_W'(1);
    end
  end

  // Update the load registers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        loads[i] <= '0;
      end
    end else if (cmd.write) begin
      loads[best] <= sum_sat;
    end
  end

  // Drive the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.write | cmd.clear;
    end
  end

  // Hold the result fields
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      server_index <= '0;
      new_load     <= '0;
      makespan     <= '0;
    end else if (cmd.write) begin
      server_index <= IDX_OUT_W'(best);
      new_load     <= sum_sat;
      makespan     <= top;
    end
  end

endmodule
